// File: design/tpcs_pkg.sv
// Package for the timer prescaler and compare solver.
// Holds widths, register indexes, status and skew codes, reset values.
// No dependencies.
package tpcs_pkg;

   localparam int FREQ_W     = 32;
   localparam int PRESC_W    = 16;
   localparam int CMP_W      = 32;
   localparam int ERR_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int SKEW_W     = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int MAX_SLOTS  = 5;
   localparam int DEF_SLOTS  = 5;
   localparam int DIV_W      = 64;

   localparam logic [STATUS_W-1:0] ST_OKAY       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IMPOSSIBLE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 2'd2;

   localparam logic [SKEW_W-1:0] SKEW_LOW      = 2'd0;
   localparam logic [SKEW_W-1:0] SKEW_HIGH     = 2'd1;
   localparam logic [SKEW_W-1:0] SKEW_EITHER   = 2'd2;
   localparam logic [SKEW_W-1:0] SKEW_RESERVED = 2'd3;   // decoded as either

   localparam logic [CSR_IDX_W-1:0] REG_SKEW      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CMP_LIMIT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_LIMIT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESC0   = 4'd3;

   localparam logic [PRESC_W-1:0] PRESC_RESET [MAX_SLOTS] =
      '{16'd1, 16'd8, 16'd64, 16'd256, 16'd1024};

   // datapath commands
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;   // latch request
   localparam logic [2:0] OP_DIV   = 3'd2;   // start a division
   localparam logic [2:0] OP_MUL   = 3'd3;   // register a product
   localparam logic [2:0] OP_KEEP  = 3'd4;   // take quotient into a register
   localparam logic [2:0] OP_BEST  = 3'd5;   // update best
   localparam logic [2:0] OP_FINAL = 3'd6;   // form result

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] sel;   // which division / product / keep
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic slot_ok;     // p nonzero and src/p > tgt and tgt nonzero
      logic cmp_ok;      // compare within limit
      logic err_stop;    // err <= limit
      logic tgt_above;   // tgt > src
   } stat_type;

endpackage

// File: design/tpcs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tpcs_pkg.
module tpcs_divider import tpcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);
   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = 7'(DIV_W);
      end else if (cnt_ff != 7'd0) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != 7'd0) || start;
   assign quotient = quo_ff;
endmodule

// File: design/tpcs_datapath.sv
// Datapath: request registers, shared divider, candidate and best registers.
// Depends on tpcs_pkg and tpcs_divider.
module tpcs_datapath import tpcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [FREQ_W-1:0]    source_hz,
   input  logic [FREQ_W-1:0]    target_hz,
   input  logic [PRESC_W-1:0]   presc,
   input  logic [SKEW_W-1:0]    skew,
   input  logic [CMP_W-1:0]     cmp_limit,
   input  logic [ERR_W-1:0]     err_limit,
   output stat_type             stat,
   output logic [STATUS_W-1:0]  status,
   output logic [PRESC_W-1:0]   chosen_prescaler,
   output logic [CMP_W-1:0]     chosen_compare,
   output logic [FREQ_W-1:0]    achieved_hz,
   output logic [ERR_W-1:0]     error_q16
);
   logic [FREQ_W-1:0]  src_ff, tgt_ff;
   logic [PRESC_W-1:0] p_ff;
   logic [DIV_W-1:0]   prod_ff, q_ff;
   logic [CMP_W:0]     cmp_ff;
   logic [FREQ_W-1:0]  ach_ff;
   logic [ERR_W-1:0]   err_ff;
   logic               have_ff;
   logic [PRESC_W-1:0] bp_ff;
   logic [CMP_W-1:0]   bc_ff;
   logic [ERR_W-1:0]   be_ff;
   logic [DIV_W-1:0]   dvd, dvs, quo, delta;
   logic               div_busy, pref_ok;

   tpcs_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.op == OP_DIV),
      .dividend(dvd), .divisor(dvs), .busy(div_busy), .quotient(quo));

   // sel: 0 src/p, 1 rounding compare, 2 achieved, 3 error, 4 final achieved
   always_comb begin
      delta = (ach_ff > tgt_ff) ? DIV_W'(ach_ff - tgt_ff) : DIV_W'(tgt_ff - ach_ff);
      case (cmd.sel)
         3'd0: begin dvd = DIV_W'(src_ff); dvs = DIV_W'(p_ff); end
         3'd1: begin dvd = (DIV_W'(src_ff) << 1) + prod_ff; dvs = prod_ff << 1; end
         3'd2: begin dvd = DIV_W'(src_ff); dvs = prod_ff; end
         3'd3: begin dvd = delta << 16; dvs = DIV_W'(tgt_ff); end
         default: begin dvd = DIV_W'(src_ff); dvs = prod_ff; end
      endcase
      case (skew)
         SKEW_HIGH: pref_ok = ach_ff >= tgt_ff;
         SKEW_LOW:  pref_ok = ach_ff <= tgt_ff;
         default:   pref_ok = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) have_ff <= 1'b0;
      else begin
         case (cmd.op)
            OP_LOAD: have_ff <= 1'b0;
            OP_BEST: if (pref_ok && (!have_ff || err_ff < be_ff)) have_ff <= 1'b1;
            default: ;
         endcase
      end
      case (cmd.op)
         OP_LOAD: begin src_ff <= source_hz; tgt_ff <= target_hz; end
         OP_MUL: begin
            p_ff <= presc;
            // sel 0: t*p, sel 1: p*cmp, sel 2: best p * best c
            case (cmd.sel)
               3'd0: prod_ff <= DIV_W'(tgt_ff) * DIV_W'(presc);
               3'd1: prod_ff <= DIV_W'(p_ff) * DIV_W'(cmp_ff[CMP_W-1:0]);
               default: prod_ff <= DIV_W'(bp_ff) * DIV_W'(bc_ff);
            endcase
         end
         OP_KEEP: begin
            case (cmd.sel)
               3'd0: q_ff <= quo;
               3'd1: cmp_ff <= (quo == '0) ? (CMP_W+1)'(1) :
                       (quo > DIV_W'(cmp_limit)) ? {1'b1, cmp_limit} :
                       (CMP_W+1)'(quo);
               3'd2: ach_ff <= FREQ_W'(quo);
               default: err_ff <= (quo > DIV_W'({ERR_W{1'b1}})) ? '1 : ERR_W'(quo);
            endcase
         end
         OP_BEST: if (pref_ok && (!have_ff || err_ff < be_ff)) begin
            bp_ff <= p_ff; bc_ff <= cmp_ff[CMP_W-1:0]; be_ff <= err_ff;
         end
         OP_FINAL: ach_ff <= FREQ_W'(quo);
         default: ;
      endcase
   end

   assign stat.div_busy  = div_busy;
   assign stat.slot_ok   = (p_ff != '0) && (tgt_ff != '0) && (q_ff > DIV_W'(tgt_ff));
   assign stat.cmp_ok    = !cmp_ff[CMP_W];
   assign stat.err_stop  = err_ff <= err_limit;
   assign stat.tgt_above = tgt_ff > src_ff;

   always_comb begin
      if (!have_ff) begin
         status = ST_IMPOSSIBLE; chosen_prescaler = '0; chosen_compare = '0;
         achieved_hz = '0; error_q16 = '0;
      end else begin
         status = (be_ff <= err_limit) ? ST_OKAY : ST_OVER_LIMIT;
         chosen_prescaler = bp_ff; chosen_compare = bc_ff;
         achieved_hz = ach_ff; error_q16 = be_ff;
      end
   end
endmodule

// File: design/tpcs_control.sv
// Controller: sequences the slot walk and the divider over the datapath.
// Depends on tpcs_pkg.
module tpcs_control import tpcs_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  logic                          rsp_fire,
   input  stat_type                      stat,
   output cmd_type                       cmd,
   output logic [$clog2(MAX_SLOTS)-1:0]  slot,
   output logic                          idle,
   output logic                          done
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_PMUL = 4'd2,
      S_DIV = 4'd3, S_WAIT = 4'd4, S_KEEP = 4'd5, S_TEST = 4'd6,
      S_MUL = 4'd7, S_BEST = 4'd8, S_NEXT = 4'd9, S_FMUL = 4'd10,
      S_FDIV = 4'd11, S_FWAIT = 4'd12, S_FKEEP = 4'd13, S_DONE = 4'd14;
   localparam int SW = $clog2(MAX_SLOTS);

   logic [3:0]    st_ff, st_in;
   logic [2:0]    ph_ff, ph_in;
   logic [SW-1:0] sl_ff, sl_in;

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; sl_in = sl_ff;
      cmd.op = OP_NONE; cmd.sel = ph_ff;
      case (st_ff)
         S_IDLE: if (req_fire) begin
            cmd.op = OP_LOAD; st_in = S_CHK; sl_in = '0;
         end
         S_CHK: st_in = stat.tgt_above ? S_DONE : S_PMUL;
         S_PMUL: begin cmd.op = OP_MUL; cmd.sel = 3'd0; ph_in = 3'd0; st_in = S_DIV; end
         S_DIV: begin cmd.op = OP_DIV; st_in = S_WAIT; end
         S_WAIT: if (!stat.div_busy) st_in = S_KEEP;
         S_KEEP: begin cmd.op = OP_KEEP; st_in = S_TEST; end
         S_TEST: begin
            case (ph_ff)
               3'd0: begin
                  ph_in = 3'd1;
                  st_in = stat.slot_ok ? S_DIV : S_NEXT;
               end
               3'd1: st_in = stat.cmp_ok ? S_MUL : S_NEXT;
               3'd2: begin ph_in = 3'd3; st_in = S_DIV; end
               default: st_in = S_BEST;
            endcase
         end
         S_MUL: begin cmd.op = OP_MUL; cmd.sel = 3'd1; ph_in = 3'd2; st_in = S_DIV; end
         S_BEST: begin
            cmd.op = OP_BEST;
            st_in = stat.err_stop ? S_FMUL : S_NEXT;
         end
         S_NEXT: begin
            if (32'(sl_ff) == SLOTS - 1) st_in = S_FMUL;
            else begin sl_in = sl_ff + SW'(1); st_in = S_PMUL; end
         end
         S_FMUL: begin cmd.op = OP_MUL; cmd.sel = 3'd2; st_in = S_FDIV; end
         S_FDIV: begin cmd.op = OP_DIV; cmd.sel = 3'd4; st_in = S_FWAIT; end
         S_FWAIT: begin cmd.sel = 3'd4; if (!stat.div_busy) st_in = S_FKEEP; end
         S_FKEEP: begin cmd.op = OP_FINAL; cmd.sel = 3'd4; st_in = S_DONE; end
         S_DONE: if (rsp_fire) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= '0; sl_ff <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; sl_ff <= sl_in;
      end
   end

   assign slot = sl_ff;
   assign idle = st_ff == S_IDLE;
   assign done = st_ff == S_DONE;
endmodule

// File: design/timer_prescaler_compare_solver.sv
// Timer prescaler and compare solver. Takes one request (source and target
// frequency) at a time and returns one result. Each searched prescaler slot
// uses four passes of the shared radix-2 divider, and a final pass forms the
// achieved frequency. A skipped slot uses one pass and a slot rejected on
// compare range two. Configuration writes are taken at any time, but
// should be made only with no request in flight.
module timer_prescaler_compare_solver import tpcs_pkg::*; #(
   parameter int PRESCALER_SLOTS = DEF_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // source_hz, target_hz
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [119:0]         rsp_tdata,   // status, chosen_prescaler,
                                             // chosen_compare, achieved_hz, error_q16, pad
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);
   logic [SKEW_W-1:0]  skew_ff;
   logic [CMP_W-1:0]   cmpl_ff;
   logic [ERR_W-1:0]   errl_ff;
   logic [PRESC_W-1:0] presc_ff [MAX_SLOTS];
   cmd_type            cmd;
   stat_type           stat;
   logic [$clog2(MAX_SLOTS)-1:0] slot;
   logic idle, done;
   logic [STATUS_W-1:0] status;
   logic [PRESC_W-1:0]  cp;
   logic [CMP_W-1:0]    cc;
   logic [FREQ_W-1:0]   ah;
   logic [ERR_W-1:0]    eq;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skew_ff <= SKEW_HIGH; cmpl_ff <= 32'd65535; errl_ff <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) presc_ff[i] <= PRESC_RESET[i];
      end else if (csr_valid) begin
         case (csr_index)
            REG_SKEW:      skew_ff <= csr_data[SKEW_W-1:0];
            REG_CMP_LIMIT: cmpl_ff <= csr_data;
            REG_ERR_LIMIT: errl_ff <= csr_data;
            default:
               for (int i = 0; i < MAX_SLOTS; i++)
                  if (csr_index == REG_PRESC0 + CSR_IDX_W'(i))
                     presc_ff[i] <= csr_data[PRESC_W-1:0];
         endcase
      end
   end

   tpcs_control #(.SLOTS(PRESCALER_SLOTS)) u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_tvalid && req_tready),
      .rsp_fire(rsp_tvalid && rsp_tready), .stat(stat), .cmd(cmd),
      .slot(slot), .idle(idle), .done(done));

   tpcs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .source_hz(req_tdata[31:0]), .target_hz(req_tdata[63:32]),
      .presc(presc_ff[slot]), .skew(skew_ff), .cmp_limit(cmpl_ff),
      .err_limit(errl_ff), .stat(stat), .status(status),
      .chosen_prescaler(cp), .chosen_compare(cc), .achieved_hz(ah),
      .error_q16(eq));

   assign req_tready = idle;
   assign rsp_tvalid = done;
   assign rsp_tdata  = {6'd0, eq, ah, cc, cp, status};
endmodule

// File: design/tpcs_checker.sv
// Port-level checks for the solver, bound to the top level.
// Depends on tpcs_pkg.
module tpcs_checker import tpcs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with result pending");
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("result too early");
   a_impossible_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ST_IMPOSSIBLE) |-> rsp_tdata[49:2] == '0)
      else $error("impossible result carries values");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

bind timer_prescaler_compare_solver tpcs_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// File: tb/timer_prescaler_compare_solver_test.sv
// Self-checking testbench for timer_prescaler_compare_solver.
// Predicts each solver result in a small class and compares it per field.
// Depends on tpcs_pkg and the solver RTL.
`timescale 1ns / 100ps

module timer_prescaler_compare_solver_test;
   import tpcs_pkg::*;

   typedef struct packed {
      logic [ERR_W-1:0]    err;
      logic [FREQ_W-1:0]   achieved;
      logic [CMP_W-1:0]    cmp;
      logic [PRESC_W-1:0]  presc;
      logic [STATUS_W-1:0] status;
   } solution_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   class solution_board;
      logic [SKEW_W-1:0]  skew;
      logic [CMP_W-1:0]   cmp_limit;
      logic [ERR_W-1:0]   err_limit;
      logic [PRESC_W-1:0] presc [MAX_SLOTS];
      solution_type pending [$];

      function void reset_regs();
         skew = SKEW_HIGH;
         cmp_limit = 32'd65535;
         err_limit = '0;
         for (int i = 0; i < MAX_SLOTS; i++) presc[i] = PRESC_RESET[i];
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == REG_SKEW) skew = val[SKEW_W-1:0];
         else if (idx == REG_CMP_LIMIT) cmp_limit = val;
         else if (idx == REG_ERR_LIMIT) err_limit = val;
         else if (idx < REG_PRESC0 + MAX_SLOTS) presc[idx - REG_PRESC0] = val[15:0];
      endfunction

      function void note_request(logic [31:0] src, logic [31:0] tgt);
         solution_type s;
         logic [63:0] p, dp, c, ach, delta, q;
         logic [31:0] e, best_e;
         logic ok, have;
         logic [63:0] best_p, best_c;
         s = '0;
         s.status = ST_IMPOSSIBLE;
         have = 1'b0; best_p = '0; best_c = '0; best_e = '0;
         if (tgt <= src) begin
            for (int i = 0; i < DEF_SLOTS; i++) begin
               p = 64'(presc[i]);
               if (p == 0 || tgt == 0) continue;
               if (src / p <= tgt) continue;
               dp = tgt * p;
               c = (2 * {32'd0, src} + dp) / (2 * dp);
               if (c < 1) c = 64'd1;
               if (c > cmp_limit) continue;
               ach = src / (p * c);
               delta = ach > tgt ? ach - tgt : tgt - ach;
               q = (delta << 16) / tgt;
               e = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
               if (skew == SKEW_HIGH) ok = ach >= tgt;
               else if (skew == SKEW_LOW) ok = ach <= tgt;
               else ok = 1'b1;
               if (ok && (!have || e < best_e)) begin
                  have = 1'b1; best_p = p; best_c = c; best_e = e;
               end
               if (e <= err_limit) break;
            end
            if (have) begin
               s.status = best_e <= err_limit ? ST_OKAY : ST_OVER_LIMIT;
               s.presc = best_p[15:0];
               s.cmp = best_c[31:0];
               ach = src / (best_p * best_c);
               s.achieved = ach[31:0];
               s.err = best_e;
            end
         end
         pending.push_back(s);
      endfunction

      task check_result(logic [119:0] data);
         solution_type got, want;
         got = data[$bits(solution_type)-1:0];
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", data[63:0], 0);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) report_mismatch("status", got.status, want.status);
         if (got.presc !== want.presc) report_mismatch("prescaler", got.presc, want.presc);
         if (got.cmp !== want.cmp) report_mismatch("compare", got.cmp, want.cmp);
         if (got.achieved !== want.achieved)
            report_mismatch("achieved", got.achieved, want.achieved);
         if (got.err !== want.err) report_mismatch("error", got.err, want.err);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [63:0] req_tdata = '0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [119:0] rsp_tdata;
   solution_board board = new();

   timer_prescaler_compare_solver uut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_index <= idx; csr_data <= val; csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // valid stays high into a request that follows with no idle cycles
   task automatic send_request(logic [31:0] src, logic [31:0] tgt);
      int idle;
      idle = $urandom_range(0, 18);
      if (idle != 0) begin
         req_tvalid <= 0;
         repeat (idle) @(negedge clock);
      end
      req_tdata <= {tgt, src}; req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_request(src, tgt);
      @(negedge clock);
   endtask

   // drain, then wait out the solver before touching registers
   task automatic wait_idle();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_freq();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1000);
         2: return $urandom_range(1_000_000, 200_000_000);
         default: return 32'hFFFF_FFFF - $urandom_range(0, 5);
      endcase
   endfunction

   task automatic random_config();
      logic [31:0] v;
      write_csr(REG_SKEW, $urandom_range(0, 3));
      v = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 70000);
      write_csr(REG_CMP_LIMIT, v == 0 ? 1 : v);
      write_csr(REG_ERR_LIMIT, $urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom);
      for (int i = 0; i < MAX_SLOTS; i++)
         write_csr(REG_PRESC0 + CSR_IDX_W'(i),
                   $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 65535));
   endtask

   // receiver with random stalls
   initial begin : receiver
      int idle;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         idle = $urandom_range(0, 18);
         if (idle != 0) begin
            rsp_tready <= 0;
            repeat (idle) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      board.reset_regs();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: reset table, edge cases
      send_request(32'd16_000_000, 32'd1000);
      send_request(32'd100, 32'd200);                  // target above source
      send_request(32'd1000, 32'd0);                   // zero target
      send_request(32'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'd1);
      send_request(32'd1000, 32'd3);
      wait_idle();
      write_csr(REG_SKEW, 32'(SKEW_LOW));
      write_csr(REG_CMP_LIMIT, 32'd1);
      write_csr(REG_ERR_LIMIT, 32'hFFFF_FFFF);           // stop at first slot within the compare limit
      for (int i = 0; i < MAX_SLOTS; i++)
         write_csr(REG_PRESC0 + CSR_IDX_W'(i), 32'h0000_FFFF);
      send_request(32'hFFFF_FFFF, 32'd1);
      send_request(32'd16_000_000, 32'd7);
      wait_idle();
      write_csr(REG_SKEW, 32'(SKEW_EITHER));
      write_csr(REG_CMP_LIMIT, 32'hFFFF_FFFF);
      write_csr(REG_ERR_LIMIT, 32'd0);
      write_csr(REG_PRESC0, 32'd0);
      write_csr(REG_PRESC0 + CSR_IDX_W'(1), 32'd3);
      write_csr(REG_PRESC0 + CSR_IDX_W'(2), 32'd3);    // tie with the slot before
      write_csr(REG_PRESC0 + CSR_IDX_W'(3), 32'd1);
      write_csr(REG_PRESC0 + CSR_IDX_W'(4), 32'd0);
      send_request(32'd1000, 32'd7);
      send_request(32'hFFFF_FFFF, 32'd3);
      send_request(32'h8000_0000, 32'h7FFF_FFFF);
      wait_idle();
      write_csr(REG_SKEW, 32'(SKEW_RESERVED));
      send_request(32'd999_999, 32'd333);
      for (int phase = 0; phase < 17; phase++) begin
         wait_idle();
         random_config();
         for (int n = 0; n < 50; n++) begin
            logic [31:0] s, t;
            s = rand_freq();
            t = $urandom_range(0, 9) == 0 ? rand_freq() : s / $urandom_range(1, 100_000);
            send_request(s, t);
         end
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
